// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/wmt_pkg.sv =====
// ----------------------------------------------------------------------------
// wmt_pkg
// Types, codes and widths shared by the watchpoint match table modules.
// ----------------------------------------------------------------------------
package wmt_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // Field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IDX_OUT_W   = 4;
  localparam int unsigned CNT_OUT_W   = 5;
  localparam int unsigned ENTRY_W     = ADDR_W + KIND_W;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_PAD_W   =
    OUT_TDATA_W - STATUS_W - 1 - IDX_OUT_W - CNT_OUT_W;

  // Request opcodes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_CLEARED    = 3'd5,
    ST_NO_TRIGGER = 3'd6,
    ST_TRIGGERED  = 3'd7
  } status_t;

  // Table write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND,
    WR_UPDATE,
    WR_SHIFT
  } wr_sel_t;

  // Entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Result index source
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_SCAN,
    IDX_COUNT
  } idx_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     take;
    logic     rd_en;
    logic     rd_next;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    logic     scan_inc;
    logic     res_we;
    status_t  res_status;
    idx_sel_t res_idx;
    logic     out_load;
  } wmt_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic scan_end;
    logic next_end;
    logic full;
    logic addr_eq;
    logic kind_hit;
    logic out_busy;
  } wmt_sts_t;

endpackage

// ===== hdl/wmt_ram.sv =====
// ----------------------------------------------------------------------------
// wmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/wmt_datapath.sv =====
// ----------------------------------------------------------------------------
// wmt_datapath
// Request latch, entry RAM, scan pointer, entry count, compare and result
// registers of the watchpoint match table.
// ----------------------------------------------------------------------------
module wmt_datapath import wmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wmt_ctl_t               ctl,
  output wmt_sts_t               sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Latched request
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [KIND_W-1:0] kind_r;
  logic              wr_r;

  // Table control
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW:0]   scan_p1;

  // Result and output registers
  status_t              res_status_r;
  logic [IW-1:0]        res_idx_r, res_idx_nxt;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_trig_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [IW+IDX_OUT_W-1:0] idx_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  // RAM ports
  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [KIND_W-1:0]  need;

  assign scan_p1 = {1'b0, scan_r} + {{CW{1'b0}}, 1'b1};

  // Request latch
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r  <= cmd_t'(in_tdata[CMD_W-1:0]);
      addr_r <= in_tdata[CMD_W+ADDR_W-1:CMD_W];
      kind_r <= in_tdata[CMD_W+ADDR_W+KIND_W-1:CMD_W+ADDR_W];
      wr_r   <= in_tdata[CMD_W+ADDR_W+KIND_W];
    end
  end

  // Entry count update
  always_comb begin
    unique case (ctl.cnt_op)
      CNT_HOLD:  count_nxt = count_r;
      CNT_CLEAR: count_nxt = '0;
      CNT_INC:   count_nxt = count_r + CW'(1);
      CNT_DEC:   count_nxt = count_r - CW'(1);
      default:   count_nxt = count_r;
    endcase
  end

  // Scan pointer update
  always_comb begin
    priority if (ctl.take) begin
      scan_nxt = '0;
    end else if (ctl.scan_inc) begin
      scan_nxt = scan_p1[CW-1:0];
    end else begin
      scan_nxt = scan_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      scan_r  <= '0;
    end else begin
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
    end
  end

  // Entry RAM write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_r[IW-1:0];
    ram_wdata = {addr_r, kind_r};
    unique case (ctl.wr_sel)
      WR_NONE: ram_we = 1'b0;
      WR_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = count_r[IW-1:0];
      end
      WR_UPDATE: ram_we = 1'b1;
      WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_raddr = ctl.rd_next ? scan_p1[IW-1:0] : scan_r[IW-1:0];

  wmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_wmt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry compare
  assign need = wr_r ? 2'b10 : 2'b01;

  assign sts.cmd      = cmd_r;
  assign sts.scan_end = (scan_r >= count_r);
  assign sts.next_end = (scan_p1 >= {1'b0, count_r});
  assign sts.full     = (count_r == CW'(MAX_ENTRIES));
  assign sts.addr_eq  = (ram_rdata[ENTRY_W-1:KIND_W] == addr_r);
  assign sts.kind_hit = |(ram_rdata[KIND_W-1:0] & need);
  assign sts.out_busy = out_valid_r & ~out_tready;

  // Result registers
  always_comb begin
    unique case (ctl.res_idx)
      IDX_ZERO:  res_idx_nxt = '0;
      IDX_SCAN:  res_idx_nxt = scan_r[IW-1:0];
      IDX_COUNT: res_idx_nxt = count_r[IW-1:0];
      default:   res_idx_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.res_we) begin
      res_status_r <= ctl.res_status;
      res_idx_r    <= res_idx_nxt;
    end
  end

  // Output register, narrowed to the field widths
  assign idx_ext = {{IDX_OUT_W{1'b0}}, res_idx_r};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= res_status_r;
      out_trig_r   <= (res_status_r == ST_TRIGGERED);
      out_idx_r    <= idx_ext[IDX_OUT_W-1:0];
      out_cnt_r    <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_idx_r, out_trig_r, out_status_r};

endmodule

// ===== hdl/wmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// wmt_ctrl
// Sequencer for the watchpoint match table: scans entries one RAM read at a
// time, compacts the table after a remove and hands results to the output.
// ----------------------------------------------------------------------------
module wmt_ctrl import wmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output wmt_ctl_t ctl,
  input  wmt_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        ctl.take = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end

      // Look at the entry under the scan pointer, or close out the search
      S_READ: begin
        if (sts.cmd == CMD_CLEAR) begin
          ctl.cnt_op     = CNT_CLEAR;
          ctl.res_we     = 1'b1;
          ctl.res_status = ST_CLEARED;
          ctl.res_idx    = IDX_ZERO;
          state_nxt      = S_FINISH;
        end else if (sts.scan_end) begin
          ctl.res_we  = 1'b1;
          ctl.res_idx = IDX_ZERO;
          state_nxt   = S_FINISH;
          unique case (sts.cmd)
            CMD_ADD: begin
              if (sts.full) begin
                ctl.res_status = ST_FULL;
              end else begin
                ctl.wr_sel     = WR_APPEND;
                ctl.cnt_op     = CNT_INC;
                ctl.res_status = ST_ADDED;
                ctl.res_idx    = IDX_COUNT;
              end
            end
            CMD_REMOVE: ctl.res_status = ST_NOT_FOUND;
            CMD_CHECK:  ctl.res_status = ST_NO_TRIGGER;
            default:    ctl.res_status = ST_CLEARED;
          endcase
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end

      // Compare the entry just read
      S_CMP: begin
        priority if (sts.cmd == CMD_ADD && sts.addr_eq) begin
          ctl.wr_sel     = WR_UPDATE;
          ctl.res_we     = 1'b1;
          ctl.res_status = ST_UPDATED;
          ctl.res_idx    = IDX_SCAN;
          state_nxt      = S_FINISH;
        end else if (sts.cmd == CMD_REMOVE && sts.addr_eq) begin
          ctl.res_we     = 1'b1;
          ctl.res_status = ST_REMOVED;
          ctl.res_idx    = IDX_SCAN;
          state_nxt      = S_SHIFT_RD;
        end else if (sts.cmd == CMD_CHECK && sts.addr_eq && sts.kind_hit) begin
          ctl.res_we     = 1'b1;
          ctl.res_status = ST_TRIGGERED;
          ctl.res_idx    = IDX_SCAN;
          state_nxt      = S_FINISH;
        end else begin
          ctl.scan_inc = 1'b1;
          state_nxt    = S_READ;
        end
      end

      // Compaction: move the next entry down one slot
      S_SHIFT_RD: begin
        if (sts.next_end) begin
          ctl.cnt_op = CNT_DEC;
          state_nxt  = S_FINISH;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_next = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ctl.wr_sel   = WR_SHIFT;
        ctl.scan_inc = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end

      // Wait for the output register to free up
      S_FINISH: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/watchpoint_match_table.sv =====
// ----------------------------------------------------------------------------
// watchpoint_match_table
// Compacted table of address watchpoints with add, remove, clear and check
// requests; one result per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload (low bit first)
//  in_      in   in_tvalid/in_tready  cmd[1:0] addr[17:2] watch_type[19:18]
//                                     wr_access[20], zero pad to 24 bits
//  out_     out  out_tvalid/out_tready status[2:0] triggered[3]
//                                     match_index[7:4] entry_count[12:8]
//
//  A request is latched, then the search reads and compares entries in turn; a
//  remove then moves each later entry down with a read and a write state, and
//  clear goes straight to the result. The search stops early on an update or a
//  trigger. The entry RAM has one read port with a registered read, so each
//  entry visit passes through a read state and a compare state.
//  Reset (synchronous, rst_n low) empties the table; entries need no clearing.
//  A finished result waits in the output register while a new request is
//  taken; a stalled output holds the sequencer only when the next result is due.
// ----------------------------------------------------------------------------
module watchpoint_match_table import wmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cmd, addr, watch_type, wr_access
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, triggered, match_index,
                                             // entry_count
);

  wmt_ctl_t ctl;
  wmt_sts_t sts;

  wmt_ctrl u_wmt_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .ctl       (ctl),
    .sts       (sts)
  );

  wmt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_wmt_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/wmt_checker.sv =====
// ----------------------------------------------------------------------------
// wmt_checker
// Port-level checks on the watchpoint match table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wmt_checker import wmt_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // One request at a time: ready drops after an accept
  `ASSERT_CLK(a_one_busy, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "request taken while busy")

  // Triggered flag agrees with the status code
  `ASSERT_CLK(a_trig_status, clk, rst_n, out_tvalid |-> (out_tdata[3] == (out_tdata[2:0] == ST_TRIGGERED)), "triggered flag disagrees with status")

  // A clear result reports an empty table
  `ASSERT_CLK(a_clear_count, clk, rst_n, out_tvalid && (out_tdata[2:0] == ST_CLEARED) |-> (out_tdata[12:8] == 5'd0), "clear left entries")

  // No result right after reset
  `ASSERT_CLK_NORST(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind watchpoint_match_table wmt_checker u_wmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/watchpoint_match_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchpoint_match_table_tb
// Self-checking bench for the watchpoint match table. A scoreboard keeps its
// own copy of the table, predicts one result per accepted request and checks
// the result stream in order. Directed requests cover the edges first. Random
// requests follow, in phases that fill and drain the table, with random
// idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module watchpoint_match_table_tb import wmt_pkg::*;;

  localparam int unsigned TABLE_DEPTH  = MAX_ENTRIES_DEF;
  localparam int unsigned RANDOM_REQS  = 600;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned PHASE_LEN    = 80;
  localparam int unsigned POOL_SIZE    = 20;

  // One expected result, fields in the order of out_tdata
  typedef struct packed {
    status_t      status;
    logic         triggered;
    logic [3:0]   match_index;
    logic [4:0]   entry_count;
  } table_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: table model and queue of predicted results
  // --------------------------------------------------------------------------
  class watch_table_scoreboard;
    logic [ADDR_W-1:0] slot_addr [TABLE_DEPTH];
    logic [KIND_W-1:0] slot_kind [TABLE_DEPTH];
    int unsigned       live_count;
    table_result_t     pending_results [$];
    int unsigned       mismatches;

    function new();
      live_count = 0;
      mismatches = 0;
    endfunction

    // First live slot holding the address, -1 if none
    function int find_slot(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < int'(live_count); i++)
        if (slot_addr[i] == addr) return i;
      return -1;
    endfunction

    // Apply one accepted request and queue its result
    function void note_request(cmd_t cmd, logic [ADDR_W-1:0] addr,
                               logic [KIND_W-1:0] kind, logic wr_access);
      table_result_t     res;
      int                hit;
      logic [KIND_W-1:0] need;
      res = '0;
      case (cmd)
        CMD_ADD: begin
          hit = find_slot(addr);
          if (hit >= 0) begin
            slot_kind[hit]  = kind;
            res.status      = ST_UPDATED;
            res.match_index = 4'(hit);
          end else if (live_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            slot_addr[live_count] = addr;
            slot_kind[live_count] = kind;
            res.match_index       = 4'(live_count);
            live_count++;
            res.status            = ST_ADDED;
          end
        end
        CMD_REMOVE: begin
          hit = find_slot(addr);
          if (hit >= 0) begin
            res.match_index = 4'(hit);
            // compact: later entries move down one slot
            for (int i = hit; i + 1 < int'(live_count); i++) begin
              slot_addr[i] = slot_addr[i+1];
              slot_kind[i] = slot_kind[i+1];
            end
            live_count--;
            res.status = ST_REMOVED;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        CMD_CLEAR: begin
          live_count = 0;
          res.status = ST_CLEARED;
        end
        default: begin
          need       = wr_access ? 2'b10 : 2'b01;
          res.status = ST_NO_TRIGGER;
          for (int i = 0; i < int'(live_count); i++) begin
            if (slot_addr[i] == addr && (slot_kind[i] & need) != '0) begin
              res.status      = ST_TRIGGERED;
              res.triggered   = 1'b1;
              res.match_index = 4'(i);
              break;
            end
          end
        end
      endcase
      res.entry_count = 5'(live_count);
      pending_results.push_back(res);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      table_result_t got;
      table_result_t want;
      got.status      = status_t'(tdata[2:0]);
      got.triggered   = tdata[3];
      got.match_index = tdata[7:4];
      got.entry_count = tdata[12:8];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d trig %0d idx %0d count %0d",
                   got.status, got.triggered, got.match_index, got.entry_count);
        return;
      end
      want = pending_results.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp status %0d trig %0d idx %0d count %0d, got status %0d trig %0d idx %0d count %0d",
                   want.status, want.triggered, want.match_index, want.entry_count,
                   got.status, got.triggered, got.match_index, got.entry_count);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // cmd, addr, watch_type, wr_access
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // status, triggered, match_index,
                                           // entry_count

  watchpoint_match_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  watch_table_scoreboard sb = new();

  int unsigned       cycle_count   = 0;
  int unsigned       results_seen  = 0;
  int                send_calm     = 0;
  int                recv_calm     = 0;
  int                sender_gap    = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle length per item; occasional stretches with no idling at all
  function automatic int draw_idle(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = 30;
    return $urandom_range(0, 18);
  endfunction

  // Offer one request and hold it until accepted, then idle for a while
  task automatic send_request(cmd_t cmd, logic [ADDR_W-1:0] addr,
                              logic [KIND_W-1:0] kind, logic wr_access);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, wr_access, kind, addr, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, addr, kind, wr_access);
    sender_gap = draw_idle(send_calm);
    if (sender_gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (sender_gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Mostly addresses from a small pool so that requests collide
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 4) == 0) return ADDR_W'($urandom());
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = (results_seen == HOLD_AT) ? LONG_HOLD : draw_idle(recv_calm);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  initial begin : request_source
    int                i;
    int                roll;
    bit                fill_phase;
    cmd_t              cmd;
    logic [KIND_W-1:0] kind;

    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (i = 2; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom());

    // single reset at start
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table
    send_request(CMD_CHECK,  16'h0000, 2'd0, 1'b0);
    send_request(CMD_REMOVE, 16'hFFFF, 2'd3, 1'b1);
    // kind zero occupies a slot but never triggers
    send_request(CMD_ADD,    16'h0000, 2'd0, 1'b0);
    send_request(CMD_CHECK,  16'h0000, 2'd3, 1'b0);
    send_request(CMD_ADD,    16'hFFFF, 2'd2, 1'b1);
    // address hit, wrong direction
    send_request(CMD_CHECK,  16'hFFFF, 2'd0, 1'b0);
    send_request(CMD_CHECK,  16'hFFFF, 2'd0, 1'b1);
    // update of an existing entry, then a hit on it
    send_request(CMD_ADD,    16'h0000, 2'd3, 1'b0);
    send_request(CMD_CHECK,  16'h0000, 2'd0, 1'b0);
    // remove at the head shifts the rest down
    send_request(CMD_REMOVE, 16'h0000, 2'd0, 1'b0);
    // fill the table
    for (i = 0; i < TABLE_DEPTH - 1; i++)
      send_request(CMD_ADD, 16'h8000 + 16'(i), 2'(i % 3 + 1), 1'b0);
    // full table: new address refused, existing one updated
    send_request(CMD_ADD,    16'h7777, 2'd3, 1'b1);
    send_request(CMD_ADD,    16'hFFFF, 2'd1, 1'b0);
    send_request(CMD_CHECK,  16'h800E, 2'd0, 1'b1);
    send_request(CMD_REMOVE, 16'h800E, 2'd0, 1'b1);
    send_request(CMD_CLEAR,  16'h5A5A, 2'd1, 1'b1);
    wait_drained();

    // random: alternate phases that grow and shrink the table
    fill_phase = 1'b1;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % PHASE_LEN == 0 && i != 0) fill_phase = !fill_phase;
      if (i == RANDOM_REQS / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (fill_phase)
        cmd = (roll < 55) ? CMD_ADD : (roll < 65) ? CMD_REMOVE :
              (roll < 66) ? CMD_CLEAR : CMD_CHECK;
      else
        cmd = (roll < 20) ? CMD_ADD : (roll < 55) ? CMD_REMOVE :
              (roll < 57) ? CMD_CLEAR : CMD_CHECK;
      kind = ($urandom_range(0, 19) == 0) ? 2'd0 : KIND_W'($urandom_range(1, 3));
      send_request(cmd, pick_addr(), kind, 1'($urandom_range(0, 1)));
    end

    // drain and let the block settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/wmt_pkg.sv
hdl/wmt_ram.sv
hdl/wmt_datapath.sv
hdl/wmt_ctrl.sv
hdl/watchpoint_match_table.sv
hdl/wmt_checker.sv
sim/watchpoint_match_table_tb.sv
